>>> rtl/core/dgpe_pkg.sv
`timescale 1ns / 1ps

package dgpe_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int SAMPLE_W   = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = SAMPLE_W * NUM_CH;
    localparam int SIZE_W     = 12;
    localparam int ENERGY_W   = 20;
    localparam int COORD_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int SUM_W      = SQ_W + 3;

    localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH   = 12'd2048;
    localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT  = 12'd2048;
    localparam logic [ENERGY_W-1:0] RST_MARGIN_ENERGY = 20'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_MARGIN_ENERGY = 2'd2,
        CFG_GRAY_MODE     = 2'd3
    } t_cfg_index;

    // per-pixel bookkeeping carried down the pipe
    typedef struct packed {
        logic                has_first;
        logic                end_row;
        logic                end_col;
        logic                margin_sel;
        logic                gray;
        logic [ENERGY_W-1:0] margin;
        logic [COORD_W-1:0]  row_first;
        logic [COORD_W-1:0]  row_second;
        logic [COORD_W-1:0]  column;
    } t_item_info;

    // one output queue entry: up to two result words
    typedef struct packed {
        logic                has_first;
        logic                end_row;
        logic                end_col;
        logic [ENERGY_W-1:0] energy;
        logic [ENERGY_W-1:0] margin;
        logic [COORD_W-1:0]  row_first;
        logic [COORD_W-1:0]  row_second;
        logic [COORD_W-1:0]  column;
    } t_result_entry;

    function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

>>> rtl/core/dgpe_line_store.sv
`timescale 1ns / 1ps

// One line of pixels: one write port, two registered read ports.
module dgpe_line_store #(
    parameter int DEPTH = dgpe_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(dgpe_pkg::DEF_MAX_WIDTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [dgpe_pkg::PIX_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr_a,
    input  logic [AW-1:0]              i_raddr_b,
    output logic [dgpe_pkg::PIX_W-1:0] o_rdata_a,
    output logic [dgpe_pkg::PIX_W-1:0] o_rdata_b
);

    logic [dgpe_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [dgpe_pkg::PIX_W-1:0] r_rdata_a;
    logic [dgpe_pkg::PIX_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/core/dual_gradient_pixel_energy.sv
`timescale 1ns / 1ps

// Dual-gradient pixel energy for seam carving. Pixels enter in raster order, one
// word per cycle, as three 8-bit channels (only channel 0 counts in gray mode).
// Pixel (r,c) gets the sum over the channels in use of (right-left)^2 +
// (below-above)^2; pixels on the image border get margin_energy. The input at
// (r,c) completes pixel (r-1,c), so results trail the input by one row; on the
// last row each input also yields its own border pixel. Every result carries its
// row and column, last_of_run marks the final word from one input and frame_done
// the bottom-right pixel. Rate: one pixel per cycle unless stalled; on the last
// row each pixel gives two words and the single output word per cycle slows the
// input. A result is registered in stage 1 and stage 2 before the output queue.
// The previous two rows sit in two line memories of MAX_WIDTH x 24 bits, each
// with one write and two read ports; their contents are undefined after reset
// and need no clearing pass, as no unwritten word feeds a gradient. Size, margin
// and mode registers may be written only while the block is empty; a new size
// takes effect at once and a counter beyond it wraps at the new edge.
module dual_gradient_pixel_energy #(
    parameter int MAX_WIDTH  = dgpe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dgpe_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [dgpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dgpe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [dgpe_pkg::SAMPLE_W-1:0]   i_sample_c0,
    input  logic [dgpe_pkg::SAMPLE_W-1:0]   i_sample_c1,
    input  logic [dgpe_pkg::SAMPLE_W-1:0]   i_sample_c2,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [dgpe_pkg::ENERGY_W-1:0]   o_energy,
    output logic [dgpe_pkg::COORD_W-1:0]    o_out_row,
    output logic [dgpe_pkg::COORD_W-1:0]    o_out_column,
    output logic                            o_last_of_run,
    output logic                            o_frame_done
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWW = (dgpe_pkg::SIZE_W > $clog2(MAX_WIDTH + 1)) ?
                         dgpe_pkg::SIZE_W : $clog2(MAX_WIDTH + 1);
    localparam int SHW = (dgpe_pkg::SIZE_W > $clog2(MAX_HEIGHT + 1)) ?
                         dgpe_pkg::SIZE_W : $clog2(MAX_HEIGHT + 1);

    // output queue; credits cover the two pipe stages as well
    localparam int FIFO_DEPTH = 4;
    localparam int FAW        = $clog2(FIFO_DEPTH);
    localparam int USED_W     = $clog2(FIFO_DEPTH + 1);

    localparam int PW = dgpe_pkg::PIX_W;
    localparam int SW = dgpe_pkg::SAMPLE_W;

    // ---------------------------------------------------------------- config
    logic [dgpe_pkg::SIZE_W-1:0]   r_frame_width;
    logic [dgpe_pkg::SIZE_W-1:0]   r_frame_height;
    logic [dgpe_pkg::ENERGY_W-1:0] r_margin_energy;
    logic                          r_gray_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= dgpe_pkg::RST_FRAME_WIDTH;
            r_frame_height  <= dgpe_pkg::RST_FRAME_HEIGHT;
            r_margin_energy <= dgpe_pkg::RST_MARGIN_ENERGY;
            r_gray_mode     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (dgpe_pkg::t_cfg_index'(i_cfg_index))
                dgpe_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= dgpe_pkg::SIZE_W'(i_cfg_data);
                end
                dgpe_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= dgpe_pkg::SIZE_W'(i_cfg_data);
                end
                dgpe_pkg::CFG_MARGIN_ENERGY: begin
                    r_margin_energy <= dgpe_pkg::ENERGY_W'(i_cfg_data);
                end
                dgpe_pkg::CFG_GRAY_MODE: begin
                    r_gray_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective last column / row: zero size acts as one, oversize as the maximum.
    logic [SWW-1:0] w_ext;
    logic [SHW-1:0] h_ext;
    logic [CW-1:0]  last_c;
    logic [RW-1:0]  last_r;

    assign w_ext = SWW'(r_frame_width);
    assign h_ext = SHW'(r_frame_height);

    always_comb begin
        if (w_ext == '0) begin
            last_c = '0;
        end else if (w_ext > SWW'(MAX_WIDTH)) begin
            last_c = CW'(MAX_WIDTH - 1);
        end else begin
            last_c = CW'(w_ext - 1'b1);
        end
        if (h_ext == '0) begin
            last_r = '0;
        end else if (h_ext > SHW'(MAX_HEIGHT)) begin
            last_r = RW'(MAX_HEIGHT - 1);
        end else begin
            last_r = RW'(h_ext - 1'b1);
        end
    end

    // ---------------------------------------------------------------- raster position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] cur_c;
    logic [RW-1:0] cur_r;
    logic [CW-1:0] col_right;
    logic [CW-1:0] col_left;
    logic          end_col;
    logic          end_row;
    logic          acc;

    logic [USED_W-1:0] r_used;

    assign o_in_stall = (r_used >= USED_W'(FIFO_DEPTH));
    assign acc        = i_in_valid && !o_in_stall;

    assign cur_c     = (r_col >= last_c) ? last_c : r_col;
    assign cur_r     = (r_row >= last_r) ? last_r : r_row;
    assign end_col   = (cur_c == last_c);
    assign end_row   = (cur_r == last_r);
    // neighbour addresses kept in range; the wrapped cases are border pixels
    assign col_right = (cur_c == CW'(MAX_WIDTH - 1)) ? '0 : cur_c + 1'b1;
    assign col_left  = (cur_c == '0) ? '0 : cur_c - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (end_col) begin
                r_col <= '0;
                r_row <= end_row ? '0 : cur_r + 1'b1;
            end else begin
                r_col <= cur_c + 1'b1;
                r_row <= cur_r;
            end
        end
    end

    // ---------------------------------------------------------------- line memories
    // line_above: written with the new pixel as it is taken; port a gives the
    // old value at this column (moves down a row), port b the right neighbour.
    // line_two_above: written by stage 1 the next cycle; a gives above, b gives left.
    logic [PW-1:0] pix;
    logic [PW-1:0] la_rd_a;
    logic [PW-1:0] la_rd_b;
    logic [PW-1:0] lt_rd_a;
    logic [PW-1:0] lt_rd_b;

    logic          r_s1_valid;
    logic [CW-1:0] r_s1_col;

    assign pix = {i_sample_c2, i_sample_c1, i_sample_c0};

    dgpe_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_above (
        .i_clk     (i_clk),
        .i_we      (acc),
        .i_waddr   (cur_c),
        .i_wdata   (pix),
        .i_re      (acc),
        .i_raddr_a (cur_c),
        .i_raddr_b (col_right),
        .o_rdata_a (la_rd_a),
        .o_rdata_b (la_rd_b)
    );

    dgpe_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_two_above (
        .i_clk     (i_clk),
        .i_we      (r_s1_valid),
        .i_waddr   (r_s1_col),
        .i_wdata   (la_rd_a),
        .i_re      (acc),
        .i_raddr_a (cur_c),
        .i_raddr_b (col_left),
        .o_rdata_a (lt_rd_a),
        .o_rdata_b (lt_rd_b)
    );

    // ---------------------------------------------------------------- stage 1
    // The item in stage 1 writes line_two_above on the same edge as the next
    // item reads it, so its data is forwarded on an address match.
    dgpe_pkg::t_item_info r_s1_info;
    logic [PW-1:0]        r_s1_pix;
    logic                 r_s1_fwd_a;
    logic                 r_s1_fwd_l;
    logic [PW-1:0]        r_s1_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix                  <= pix;
            r_s1_col                  <= cur_c;
            r_s1_fwd_a                <= r_s1_valid && (r_s1_col == cur_c);
            r_s1_fwd_l                <= r_s1_valid && (r_s1_col == col_left);
            r_s1_fwd_data             <= la_rd_a;
            r_s1_info.has_first       <= (cur_r != '0);
            r_s1_info.end_row         <= end_row;
            r_s1_info.end_col         <= end_col;
            r_s1_info.margin_sel      <= (cur_r == RW'(1)) || (cur_c == '0) || end_col;
            r_s1_info.gray            <= r_gray_mode;
            r_s1_info.margin          <= r_margin_energy;
            r_s1_info.row_first       <= dgpe_pkg::COORD_W'(cur_r - 1'b1);
            r_s1_info.row_second      <= dgpe_pkg::COORD_W'(cur_r);
            r_s1_info.column          <= dgpe_pkg::COORD_W'(cur_c);
        end
    end

    logic [PW-1:0] px_above;
    logic [PW-1:0] px_left;
    logic [PW-1:0] px_right;
    logic [dgpe_pkg::SQ_W-1:0] sq_h [dgpe_pkg::NUM_CH];
    logic [dgpe_pkg::SQ_W-1:0] sq_v [dgpe_pkg::NUM_CH];

    assign px_above = r_s1_fwd_a ? r_s1_fwd_data : lt_rd_a;
    assign px_left  = r_s1_fwd_l ? r_s1_fwd_data : lt_rd_b;
    assign px_right = la_rd_b;

    always_comb begin
        logic [SW-1:0] dh;
        logic [SW-1:0] dv;
        for (int k = 0; k < dgpe_pkg::NUM_CH; k++) begin
            dh      = dgpe_pkg::abs_diff(px_right[k*SW +: SW], px_left[k*SW +: SW]);
            dv      = dgpe_pkg::abs_diff(r_s1_pix[k*SW +: SW], px_above[k*SW +: SW]);
            sq_h[k] = dgpe_pkg::SQ_W'(dh) * dgpe_pkg::SQ_W'(dh);
            sq_v[k] = dgpe_pkg::SQ_W'(dv) * dgpe_pkg::SQ_W'(dv);
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic                      r_s2_valid;
    dgpe_pkg::t_item_info      r_s2_info;
    logic [dgpe_pkg::SQ_W-1:0] r_s2_sq_h [dgpe_pkg::NUM_CH];
    logic [dgpe_pkg::SQ_W-1:0] r_s2_sq_v [dgpe_pkg::NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_info <= r_s1_info;
            for (int k = 0; k < dgpe_pkg::NUM_CH; k++) begin
                r_s2_sq_h[k] <= sq_h[k];
                r_s2_sq_v[k] <= sq_v[k];
            end
        end
    end

    logic [dgpe_pkg::SUM_W-1:0] sum_c0;
    logic [dgpe_pkg::SUM_W-1:0] sum_c12;
    logic [dgpe_pkg::SUM_W-1:0] sum_all;
    logic                       push;
    logic                       drop;
    dgpe_pkg::t_result_entry    push_entry;

    assign sum_c0  = dgpe_pkg::SUM_W'(r_s2_sq_h[0]) + dgpe_pkg::SUM_W'(r_s2_sq_v[0]);
    assign sum_c12 = dgpe_pkg::SUM_W'(r_s2_sq_h[1]) + dgpe_pkg::SUM_W'(r_s2_sq_v[1])
                   + dgpe_pkg::SUM_W'(r_s2_sq_h[2]) + dgpe_pkg::SUM_W'(r_s2_sq_v[2]);
    assign sum_all = r_s2_info.gray ? sum_c0 : sum_c0 + sum_c12;

    // a first-row pixel of a taller frame yields nothing and frees its credit
    assign push = r_s2_valid && (r_s2_info.has_first || r_s2_info.end_row);
    assign drop = r_s2_valid && !(r_s2_info.has_first || r_s2_info.end_row);

    always_comb begin
        push_entry.has_first  = r_s2_info.has_first;
        push_entry.end_row    = r_s2_info.end_row;
        push_entry.end_col    = r_s2_info.end_col;
        push_entry.energy     = r_s2_info.margin_sel ? r_s2_info.margin
                                                     : dgpe_pkg::ENERGY_W'(sum_all);
        push_entry.margin     = r_s2_info.margin;
        push_entry.row_first  = r_s2_info.row_first;
        push_entry.row_second = r_s2_info.row_second;
        push_entry.column     = r_s2_info.column;
    end

    // ---------------------------------------------------------------- output queue
    dgpe_pkg::t_result_entry r_fifo [FIFO_DEPTH];
    logic [FAW-1:0]          r_wr_ptr;
    logic [FAW-1:0]          r_rd_ptr;
    logic [USED_W-1:0]       r_fifo_cnt;
    logic                    r_phase;
    dgpe_pkg::t_result_entry head;
    logic                    show_first;
    logic                    out_take;
    logic                    pop;

    assign head        = r_fifo[r_rd_ptr];
    assign o_out_valid = (r_fifo_cnt != '0);
    assign show_first  = head.has_first && !r_phase;
    assign out_take    = o_out_valid && !i_out_stall;
    assign pop         = out_take && !(show_first && head.end_row);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_phase    <= 1'b0;
            r_used     <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (out_take) begin
                r_phase <= show_first && head.end_row;
            end
            r_fifo_cnt <= r_fifo_cnt + USED_W'(push) - USED_W'(pop);
            r_used     <= r_used + USED_W'(acc) - USED_W'(pop) - USED_W'(drop);
        end
    end

    assign o_energy      = show_first ? head.energy : head.margin;
    assign o_out_row     = show_first ? head.row_first : head.row_second;
    assign o_out_column  = head.column;
    assign o_last_of_run = show_first ? !head.end_row : 1'b1;
    assign o_frame_done  = show_first ? 1'b0 : head.end_col;

    // ---------------------------------------------------------------- assertions
    // credits in use match what sits in the pipe and the queue
    a_credit_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == r_fifo_cnt + USED_W'(r_s1_valid) + USED_W'(r_s2_valid))
        else $error("credit count out of step with pipe and queue");

    // second half of an entry only after a first result on the last row
    a_phase_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (o_out_valid && head.has_first && head.end_row))
        else $error("output phase set on an entry without a pending margin word");

    // every queued entry carries at least one result
    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (head.has_first || head.end_row))
        else $error("empty entry at head of output queue");

    // a pop leaves the queue on the next edge one entry shorter unless refilled
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_fifo_cnt == $past(r_fifo_cnt) - 1'b1))
        else $error("queue count wrong after pop");

endmodule
